@@ design/nwtc_pkg.sv @@
// Package for the near-plane triangle clipper.
// Holds vertex in/out beat types, the divider control type, field constants and register indices. No dependencies.
package nwtc_pkg;
	localparam int VFIELDS = 10;
	localparam int W_IDX = 3;

	localparam logic REG_NEAR_W = 1'b0;
	localparam logic REG_ACTIVE_ATTRS = 1'b1;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] pos_w;
		logic signed [31:0] attr_0;
		logic signed [31:0] attr_1;
		logic signed [31:0] attr_2;
		logic signed [31:0] attr_3;
		logic signed [31:0] attr_4;
		logic signed [31:0] attr_5;
	} vtx_in_t;

	typedef struct packed {
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_pos_z;
		logic signed [31:0] out_pos_w;
		logic signed [31:0] out_attr_0;
		logic signed [31:0] out_attr_1;
		logic signed [31:0] out_attr_2;
		logic signed [31:0] out_attr_3;
		logic signed [31:0] out_attr_4;
		logic signed [31:0] out_attr_5;
		logic last_vertex;
	} vtx_out_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;
endpackage

@@ design/nwtc_div.sv @@
// Restoring divider for the clip parameter t, one quotient bit per cycle.
// Depends on nwtc_pkg.
module nwtc_div
	import nwtc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [32:0] num,
	input  logic [32:0] den,
	output div_ctl_t ctl,
	output logic [FRAC_BITS-1:0] quo
);
	localparam int NB = 33 + FRAC_BITS;
	localparam int CW = $clog2(NB + 1);

	logic [NB-1:0] dvd_q;
	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic [CW-1:0] cnt_q;
	logic [33:0] trial;

	assign trial = {rem_q[32:0], dvd_q[NB-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NB);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!trial[33]) begin
				rem_q <= trial;
				dvd_q <= {dvd_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[32:0], dvd_q[NB-1]};
				dvd_q <= {dvd_q[NB-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy = (cnt_q != '0);
	assign quo = dvd_q[FRAC_BITS-1:0];
endmodule

@@ design/nwtc_lerp.sv @@
// Shared interpolation unit: c_in + round((c_out - c_in) * t), one field per use.
// Registered product, then registered sum. Depends on nwtc_pkg.
module nwtc_lerp
	import nwtc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic signed [31:0] c_in,
	input  logic signed [31:0] c_out,
	input  logic [FRAC_BITS-1:0] t,
	output logic signed [31:0] res
);
	logic signed [32:0] d;
	logic signed [33+FRAC_BITS:0] prod_s1;
	logic signed [31:0] cin_s1;
	logic signed [33+FRAC_BITS:0] rnd;

	assign d = 33'(c_out) - 33'(c_in);

	always_ff @(posedge clk) begin
		prod_s1 <= d * $signed({1'b0, t});
		cin_s1 <= c_in;
	end

	assign rnd = prod_s1 + (FRAC_BITS+34)'(1 << (FRAC_BITS - 1));

	always_ff @(posedge clk) begin
		res <= cin_s1 + 32'(rnd >>> FRAC_BITS);
	end
endmodule

@@ design/near_w_triangle_clipper_core.sv @@
// Top level of the near-plane triangle clipper.
// Depends on nwtc_pkg, nwtc_div, nwtc_lerp.
//
//  channel | signals                           | dir
//  in      | in_valid, in_stall, in_data       | vertex beats in
//  out     | out_valid, out_stall, out_data    | polygon vertex beats out
//  cfg     | cfg_we, cfg_index, cfg_data       | register writes
//
// The first two vertices of a triangle are stored as they arrive. The third
// vertex starts the inside mask, then each beat is planned and emitted; each
// crossing adds a divide of 33 + FRAC_BITS steps and 10 fields, one at a time,
// through the shared multiplier. Output stall holds the emitting beat.
// Reset clears phase and sequencer and sets the config registers to defaults; the vertex store is not cleared.
module near_w_triangle_clipper_core
	import nwtc_pkg::*;
#(
	parameter int NUM_ATTRS = 6,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  vtx_in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output vtx_out_t out_data,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [30:0] cfg_data
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PLAN = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_LERP = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;
	localparam logic [2:0] S_WAIT = 3'd5;

	localparam logic [1:0] E_NONE = 2'd0;
	localparam logic [1:0] E_END  = 2'd1;
	localparam logic [1:0] E_X    = 2'd2;
	localparam logic [1:0] E_XEND = 2'd3;

	logic [30:0] near_q;
	logic [2:0] attrs_q;
	logic [1:0] phase_q;
	logic [2:0] state_q;
	logic [31:0] store_q [3][VFIELDS];
	logic [31:0] buf_q [VFIELDS];
	logic [2:0] in_q;
	logic [1:0] edge_q;
	logic sub_q;
	logic all_in_q;
	logic [2:0] left_q;
	logic [3:0] fld_q;
	logic [3:0] wr_q;
	logic [1:0] dly_q;
	logic div_start;
	logic walk;
	div_ctl_t dctl;
	logic [FRAC_BITS-1:0] t;
	logic signed [31:0] lres;
	logic [1:0] ia, ib, ii, io;
	logic [1:0] act;
	logic in_acc, out_acc;
	logic [32:0] num, den;
	logic [2:0] lanes;
	vtx_in_t in_d;

	assign lanes = (attrs_q > 3'(NUM_ATTRS)) ? 3'(NUM_ATTRS) : attrs_q;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_d = in_data;

	always_comb begin
		ia = edge_q;
		ib = (edge_q == 2'd2) ? 2'd0 : edge_q + 2'd1;
		ii = in_q[ia] ? ia : ib;
		io = in_q[ia] ? ib : ia;
		if (all_in_q) begin
			act = E_END;
		end else if (in_q[ia] && in_q[ib]) begin
			act = E_END;
		end else if (in_q[ia]) begin
			act = E_X;
		end else if (in_q[ib]) begin
			act = E_XEND;
		end else begin
			act = E_NONE;
		end
	end

	// mask cycles use left_q 0 and 7; edges are walked with 1..4 beats left
	assign walk = (left_q != 3'd0) && (left_q != 3'd7);

	assign num = 33'($signed(store_q[ii][W_IDX])) - 33'(near_q);
	assign den = 33'($signed(store_q[ii][W_IDX])) - 33'($signed(store_q[io][W_IDX]));
	assign div_start = (state_q == S_PLAN) && walk &&
		(act == E_X || (act == E_XEND && !sub_q));

	nwtc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num), .den(den), .ctl(dctl), .quo(t)
	);

	nwtc_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
		.clk(clk), .c_in(store_q[ii][fld_q]), .c_out(store_q[io][fld_q]),
		.t(t), .res(lres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= 31'd6554;
			attrs_q <= 3'd6;
		end else if (cfg_we) begin
			if (cfg_index == REG_NEAR_W) begin
				near_q <= cfg_data;
			end else begin
				attrs_q <= cfg_data[2:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			store_q[(phase_q == 2'd3) ? 2'd0 : phase_q] <= '{in_d.pos_x, in_d.pos_y,
				in_d.pos_z, in_d.pos_w, in_d.attr_0, in_d.attr_1, in_d.attr_2,
				in_d.attr_3, in_d.attr_4, in_d.attr_5};
		end
		if (state_q == S_PLAN && (act == E_END || (act == E_XEND && sub_q))) begin
			// all inside passes v0, v1, v2 in order
			if (all_in_q) begin
				buf_q <= store_q[ia];
			end else begin
				buf_q <= store_q[ib];
			end
		end
		if (state_q == S_LERP && dly_q == 2'd0) begin
			buf_q[wr_q] <= lres;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			state_q <= S_IDLE;
			in_q <= '0;
			edge_q <= '0;
			sub_q <= 1'b0;
			all_in_q <= 1'b0;
			left_q <= '0;
			fld_q <= '0;
			wr_q <= '0;
			dly_q <= '0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (phase_q == 2'd2) begin
							phase_q <= 2'd0;
							state_q <= S_PLAN;
						end else if (phase_q == 2'd3) begin
							phase_q <= 2'd1;
						end else begin
							phase_q <= phase_q + 2'd1;
						end
					end
				end
				S_PLAN: begin
					// first pass: compute inside mask and count
					if (edge_q == 2'd0 && !sub_q && left_q == 3'd0) begin
						in_q[0] <= $signed(store_q[0][W_IDX]) >= $signed({1'b0, near_q});
						in_q[1] <= $signed(store_q[1][W_IDX]) >= $signed({1'b0, near_q});
						in_q[2] <= $signed(store_q[2][W_IDX]) >= $signed({1'b0, near_q});
						left_q <= 3'd7;
					end else if (left_q == 3'd7) begin
						all_in_q <= &in_q;
						left_q <= (&in_q) ? 3'd3 :
							((in_q == 3'b000) ? 3'd0 :
							(($countones(in_q) == 2) ? 3'd4 : 3'd3));
						edge_q <= 2'd0;
						sub_q <= 1'b0;
						if (in_q == 3'b000) begin
							state_q <= S_IDLE;
						end
					end else if (act == E_NONE) begin
						edge_q <= edge_q + 2'd1;
					end else if (act == E_END || (act == E_XEND && sub_q)) begin
						state_q <= S_EMIT;
						out_valid <= 1'b1;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!dctl.busy && !dctl.start) begin
						state_q <= S_LERP;
						fld_q <= '0;
						dly_q <= 2'd2;
					end
				end
				S_LERP: begin
					if (dly_q != 2'd0) begin
						dly_q <= dly_q - 2'd1;
						wr_q <= fld_q;
					end else if (wr_q == 4'(VFIELDS - 1)) begin
						state_q <= S_EMIT;
						out_valid <= 1'b1;
					end else begin
						fld_q <= wr_q + 4'd1;
						dly_q <= 2'd2;
					end
				end
				S_EMIT: begin
					if (out_acc) begin
						out_valid <= 1'b0;
						left_q <= left_q - 3'd1;
						if (left_q == 3'd1) begin
							state_q <= S_WAIT;
						end else begin
							state_q <= S_PLAN;
							if (act == E_XEND && !sub_q) begin
								sub_q <= 1'b1;
							end else begin
								sub_q <= 1'b0;
								edge_q <= edge_q + 2'd1;
							end
						end
					end
				end
				S_WAIT: begin
					state_q <= S_IDLE;
					edge_q <= '0;
					sub_q <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic [31:0] ov [VFIELDS];
	always_comb begin
		ov = buf_q;
		for (int k = 4; k < VFIELDS; k++) begin
			if (k - 4 >= int'(lanes)) begin
				ov[k] = '0;
			end
		end
	end

	assign out_data = '{ov[0], ov[1], ov[2], ov[3], ov[4], ov[5], ov[6], ov[7],
		ov[8], ov[9], (left_q == 3'd1)};

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("output beat while taking input");
	assert property (@(posedge clk) disable iff (!arst_n)
		dctl.busy |-> state_q == S_DIV) else $error("divider busy outside divide");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("output beat dropped");
endmodule
